>>> src/b64e_pkg.sv
// b64e_pkg: shared types, constants and the base64 alphabet lookup
// used by the base64 encoder front end, job queue and character back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CHAR_W   = 7;
   localparam int SEXTET_W = 6;
   localparam int SLOTS    = 4;
   localparam int SLOT_W   = $clog2(SLOTS);

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;  // '='

   // One accepted byte, classified into the characters it produces.
   typedef struct packed {
      logic [SLOTS-1:0][CHAR_W-1:0] chars;     // slot 0 goes out first
      logic [SLOT_W-1:0]            last_slot; // index of the last slot to send
      logic                         fin;       // last slot ends the message
   } job_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [CHAR_W-1:0] enc6(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] wide;
      logic [CHAR_W-1:0] code;
      wide = CHAR_W'(v);
      priority if (v < 6'd26) begin
         code = wide + 7'd65;             // 'A'
      end else if (v < 6'd52) begin
         code = wide + 7'd71;             // 'a' - 26
      end else if (v < 6'd62) begin
         code = wide - 7'd4;              // '0' - 52
      end else if (v == 6'd62) begin
         code = 7'h2B;                    // '+'
      end else begin
         code = 7'h2F;                    // '/'
      end
      return code;
   endfunction

endpackage

`default_nettype wire

>>> src/b64e_front.sv
// b64e_front: accepts raw bytes, tracks group phase and leftover bits, and
// turns each byte into a job of up to four characters.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_final_byte,
   input  wire logic                 queue_full,
   output logic                      job_write,
   output b64e_pkg::job_type         job
);

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   assign job_write = req_push && !queue_full;

   always_comb begin
      job       = '0;
      phase_in  = phase_ff;
      carry_in  = carry_ff;
      unique case (phase_ff)
         PH_SECOND: begin
            job.chars[0] = b64e_pkg::enc6({carry_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               job.chars[1]  = b64e_pkg::enc6({req_data_byte[3:0], 2'b00});
               job.chars[2]  = b64e_pkg::PAD_CHAR;
               job.last_slot = 2'd2;
               job.fin       = 1'b1;
               phase_in      = PH_FIRST;
               carry_in      = 4'd0;
            end else begin
               job.last_slot = 2'd0;
               phase_in      = PH_THIRD;
               carry_in      = req_data_byte[3:0];
            end
         end
         PH_THIRD: begin
            job.chars[0]  = b64e_pkg::enc6({carry_ff, req_data_byte[7:6]});
            job.chars[1]  = b64e_pkg::enc6(req_data_byte[5:0]);
            job.last_slot = 2'd1;
            job.fin       = req_final_byte;
            phase_in      = PH_FIRST;
            carry_in      = 4'd0;
         end
         default: begin
            // first byte of a group; unused phase code behaves the same
            job.chars[0] = b64e_pkg::enc6(req_data_byte[7:2]);
            if (req_final_byte) begin
               job.chars[1]  = b64e_pkg::enc6({req_data_byte[1:0], 4'b0000});
               job.chars[2]  = b64e_pkg::PAD_CHAR;
               job.chars[3]  = b64e_pkg::PAD_CHAR;
               job.last_slot = 2'd3;
               job.fin       = 1'b1;
               phase_in      = PH_FIRST;
               carry_in      = 4'd0;
            end else begin
               job.last_slot = 2'd0;
               phase_in      = PH_SECOND;
               carry_in      = {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= 4'd0;
      end else if (job_write) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b64e_queue.sv
// b64e_queue: short register queue of jobs between front end and back end.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
   parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire b64e_pkg::job_type wr_job,
   output logic                   full,
   input  wire logic              rd_en,
   output b64e_pkg::job_type      rd_job,
   output logic                   rd_valid
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   b64e_pkg::job_type   slots_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   assign full     = (count_ff == FullCnt);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> src/b64e_back.sv
// b64e_back: walks the characters of the head job one per cycle, unless rsp_pop
// stalls, into a registered result stage. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire b64e_pkg::job_type             head_job,
   input  wire logic                          head_valid,
   output logic                               head_done,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [b64e_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                               rsp_final_char
);

   logic [b64e_pkg::SLOT_W-1:0] slot_ff;
   logic                        out_valid_ff;
   logic [b64e_pkg::CHAR_W-1:0] out_char_ff;
   logic                        out_final_ff;
   logic                        load;
   logic                        last;

   // refill the result stage when it is free or being taken this cycle
   assign load      = head_valid && (!out_valid_ff || rsp_pop);
   assign last      = (slot_ff == head_job.last_slot);
   assign head_done = load && last;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_final_char = out_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            slot_ff      <= last ? '0 : slot_ff + 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff  <= head_job.chars[slot_ff];
         out_final_ff <= last && head_job.fin;
      end
   end

endmodule

`default_nettype wire

>>> src/base64_encoder.sv
// base64_encoder: streaming base64 encoder with '=' padding, built from
// b64e_front, b64e_queue and b64e_back. Depends on b64e_pkg.
// The first character of a byte reaches rsp_ through the job queue, then the
// registered result stage. Throughput: one character per cycle out while rsp_pop
// takes it; a byte gives 1 to 4 characters, 4 per 3 bytes, so the output sets the rate.
// Reset (synchronous): queue and result stage empty, next byte starts a group.
`timescale 1ns / 1ps
`default_nettype none

module base64_encoder #(
   parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input queue side: one raw byte per transfer
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_final_byte,
   // result queue side: one ASCII character per transfer
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [b64e_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                               rsp_final_char
);

   b64e_pkg::job_type wr_job;
   b64e_pkg::job_type head_job;
   logic              job_write;
   logic              queue_full;
   logic              head_valid;
   logic              head_done;

   // Hold off new bytes only while the job queue is full. req_full does not
   // look at rsp_pop; a stalled result transfer backs up through the queue
   // and holds off the input once the queue has filled.
   assign req_full = queue_full;

   // Front: classify each byte by its place in the group and build its
   // character list, padding included when the byte ends the message.
   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .job_write      (job_write),
      .job            (wr_job)
   );

   // Queue: decouple byte intake from character output.
   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_write),
      .wr_job   (wr_job),
      .full     (queue_full),
      .rd_en    (head_done),
      .rd_job   (head_job),
      .rd_valid (head_valid)
   );

   // Back: advance through the head job one character per cycle unless rsp_pop
   // stalls, and drop it from the queue as its last character moves into the result stage.
   b64e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .head_valid     (head_valid),
      .head_done      (head_done),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char)
   );

endmodule

`default_nettype wire

>>> bench/base64_encoder_checker.sv
// base64_encoder_checker: watches both queue ports of the base64 encoder,
// predicts the characters of every accepted byte and compares each transfer.
// Depends on b64e_pkg for the character width and the pad character.
`timescale 1ns / 1ps

module base64_encoder_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   input  wire logic                        req_full,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_final_byte,
   input  wire logic                        rsp_empty,
   input  wire logic                        rsp_pop,
   input  wire logic [b64e_pkg::CHAR_W-1:0] rsp_out_char,
   input  wire logic                        rsp_final_char,
   output int                               fail_count,
   output int                               chars_waiting,
   output int                               bytes_seen,
   output int                               messages_seen,
   output int                               chars_seen
);

   typedef enum logic [1:0] {
      GROUP_FIRST  = 2'd0,
      GROUP_SECOND = 2'd1,
      GROUP_THIRD  = 2'd2,
      GROUP_UNUSED = 2'd3
   } group_pos_type;

   typedef struct packed {
      logic [b64e_pkg::CHAR_W-1:0] code;
      logic                        last;
   } b64_char_type;

   b64_char_type  char_q[$];
   group_pos_type group_pos;
   logic [3:0]    leftover;

   initial begin
      fail_count    = 0;
      chars_waiting = 0;
      bytes_seen    = 0;
      messages_seen = 0;
      chars_seen    = 0;
      group_pos     = GROUP_FIRST;
      leftover      = 4'd0;
   end

   function automatic logic [b64e_pkg::CHAR_W-1:0] sextet_char(input logic [5:0] v);
      string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return b64e_pkg::CHAR_W'(alphabet[v]);
   endfunction

   task automatic queue_char(input logic [b64e_pkg::CHAR_W-1:0] code, input logic last);
      b64_char_type c;
      c.code = code;
      c.last = last;
      char_q.push_back(c);
   endtask

   // Encode one byte against the running group position and leftover bits.
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      case (group_pos)
         GROUP_SECOND: begin
            queue_char(sextet_char({leftover[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               queue_char(sextet_char({b[3:0], 2'b00}), 1'b0);
               queue_char(b64e_pkg::PAD_CHAR, 1'b1);
               group_pos = GROUP_FIRST;
               leftover  = 4'd0;
            end else begin
               group_pos = GROUP_THIRD;
               leftover  = b[3:0];
            end
         end
         GROUP_THIRD: begin
            queue_char(sextet_char({leftover, b[7:6]}), 1'b0);
            queue_char(sextet_char(b[5:0]), fin);
            group_pos = GROUP_FIRST;
            leftover  = 4'd0;
         end
         default: begin
            // unused position falls back to a group start
            queue_char(sextet_char(b[7:2]), 1'b0);
            if (fin) begin
               queue_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
               queue_char(b64e_pkg::PAD_CHAR, 1'b0);
               queue_char(b64e_pkg::PAD_CHAR, 1'b1);
               group_pos = GROUP_FIRST;
               leftover  = 4'd0;
            end else begin
               group_pos = GROUP_SECOND;
               leftover  = {2'b00, b[1:0]};
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      b64_char_type want;
      if (reset) begin
         char_q.delete();
         group_pos = GROUP_FIRST;
         leftover  = 4'd0;
      end else begin
         if (req_push && !req_full) begin
            encode_byte(req_data_byte, req_final_byte);
            bytes_seen++;
            if (req_final_byte) messages_seen++;
         end
         if (rsp_pop && !rsp_empty) begin
            chars_seen++;
            if (char_q.size() == 0) begin
               $error("rsp_out_char: expected nothing, actual 0x%02h (final_char %0b)",
                      rsp_out_char, rsp_final_char);
               fail_count++;
            end else begin
               want = char_q.pop_front();
               if (rsp_out_char !== want.code) begin
                  $error("rsp_out_char: expected 0x%02h, actual 0x%02h",
                         want.code, rsp_out_char);
                  fail_count++;
               end
               if (rsp_final_char !== want.last) begin
                  $error("rsp_final_char: expected %0b, actual %0b",
                         want.last, rsp_final_char);
                  fail_count++;
               end
            end
         end
      end
      chars_waiting <= char_q.size();
   end

endmodule

>>> bench/base64_encoder_test.sv
// base64_encoder_test: top of the encoder bench; drives bytes in bursts,
// pops characters on a shifting stall pattern and gives the verdict.
// Depends on b64e_pkg, base64_encoder and base64_encoder_checker.
`timescale 1ns / 1ps

module base64_encoder_test;

   localparam int RANDOM_BYTES = 420;
   localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 20;

   // Receiver stall styles, each held for a random stretch.
   typedef enum logic [1:0] {
      POP_ALWAYS,
      POP_HALF,
      POP_SPARSE,
      POP_STALLS
   } pop_style_type;

   logic                          clock;
   logic                          reset          = 1'b1;
   logic                          req_push       = 1'b0;
   logic                          req_full;
   logic [7:0]                    req_data_byte  = 8'h00;
   logic                          req_final_byte = 1'b0;
   logic                          rsp_empty;
   logic                          rsp_pop        = 1'b0;
   logic [b64e_pkg::CHAR_W-1:0]   rsp_out_char;
   logic                          rsp_final_char;

   int fail_count;
   int chars_waiting;
   int bytes_seen;
   int messages_seen;
   int chars_seen;

   int burst_left = 0;
   int idle_cycles = 0;

   base64_encoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char)
   );

   base64_encoder_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char),
      .fail_count     (fail_count),
      .chars_waiting  (chars_waiting),
      .bytes_seen     (bytes_seen),
      .messages_seen  (messages_seen),
      .chars_seen     (chars_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one byte and hold it until the transfer. Between bursts, drop
   // push for a random gap and scramble the idle data lines.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      req_push       <= 1'b1;
      req_data_byte  <= value;
      req_final_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (burst_left == 0) begin
         // mostly short bursts, now and then a long run with no idling
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 16);
         if (gap != 0) begin
            req_push       <= 1'b0;
            req_data_byte  <= 8'($urandom);
            req_final_byte <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold off the sender until every predicted character has been popped.
   task automatic drain_outputs();
      req_push <= 1'b0;
      @(posedge clock);
      while (chars_waiting != 0) @(posedge clock);
   endtask

   // One message of random bytes; the extremes turn up often.
   task automatic send_message(input int len);
      logic [7:0] value;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'($urandom_range(0, 255));
         endcase
         send_byte(value, i == len - 1);
      end
   endtask

   // Receiver: pick a stall style for a random stretch and pop accordingly.
   pop_style_type pop_style = POP_ALWAYS;
   int            style_left = 0;
   int            stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (style_left == 0) begin
            pop_style  = pop_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 96);
         end else begin
            style_left--;
         end
         case (pop_style)
            POP_ALWAYS: rsp_pop <= 1'b1;
            POP_HALF:   rsp_pop <= 1'($urandom);
            POP_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
            default: begin
               // long stalls broken by runs of pops
               if (stall_left != 0) begin
                  stall_left--;
                  rsp_pop <= 1'b0;
               end else begin
                  rsp_pop <= 1'b1;
                  if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   // Watchdog: end the run when neither side has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_bytes;
      int len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-byte messages end at the first group position (two pads)
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two-byte messages end at the second position (one pad)
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // full group ending the message at the third position
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // plain text, low carry bits matter in the second position
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      // the '+' symbol character of the alphabet, in every position
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // full group, then a partial one: leftover bits must clear
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_outputs();

      // Random messages, mostly short, a few long ones
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
            6, 7, 8:          len = $urandom_range(7, 15);
            default:          len = $urandom_range(16, 40);
         endcase
         send_message(len);
         random_bytes += len;
         if ($urandom_range(0, 7) == 0) drain_outputs();
      end

      // Wait for the last characters, then watch a quiet stretch of DRAIN_CYCLES
      req_push <= 1'b0;
      @(posedge clock);
      while (chars_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d bytes in %0d messages, %0d characters checked,",
               bytes_seen, messages_seen, chars_seen);
      $display("with bursty input gaps, output stalls and drained pauses.");
      if (fail_count == 0 && chars_waiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> base64_encoder.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_encoder.sv
bench/base64_encoder_checker.sv
bench/base64_encoder_test.sv
